>>> rtl/ordered_dither_rgb32_to_rgb16_top_assert.svh
// ----------------------------------------------------------------------------
// Ordered dither reducer assertion macros
// Concurrent check macros used by the top level; they vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_RGB32_TO_RGB16_TOP_ASSERT_SVH
`define ORDERED_DITHER_RGB32_TO_RGB16_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is disabled while reset is asserted.
`define ODRGB_ASSERT(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("odrgb check failed");

// Clocked check that also holds while reset is asserted.
`define ODRGB_ASSERT_ALWAYS(label, clock, prop) \
    label: assert property (@(posedge clock) prop) \
        else $error("odrgb check failed");

`else

`define ODRGB_ASSERT(label, clock, resetn, prop)

`define ODRGB_ASSERT_ALWAYS(label, clock, prop)

`endif

`endif

>>> rtl/odrgb_pkg.sv
// ----------------------------------------------------------------------------
// Ordered dither reducer package
// Word types, constants and the 4x4 dither matrix shared by the RTL files.
// ----------------------------------------------------------------------------
package odrgb_pkg;

    // Default side length of the square macroblock.
    localparam int BLOCK_SIDE_DEFAULT = 16;

    // Alpha code that sets the output alpha bit.
    localparam logic [7:0] ALPHA_MATCH = 8'h40;

    // Width of a signed dither coefficient.
    localparam int COEFF_W = 4;

    // Ordered dither matrix, indexed by row mod 4 and column mod 4.
    localparam logic signed [COEFF_W-1:0] DITHER_MATRIX [4][4] = '{
        '{-4'sd4,  4'sd0, -4'sd3,  4'sd1},
        '{ 4'sd2, -4'sd2,  4'sd3, -4'sd1},
        '{-4'sd3,  4'sd1, -4'sd4,  4'sd0},
        '{ 4'sd3, -4'sd1,  4'sd2, -4'sd2}
    };

    // Input word: one RGBA pixel.
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    // Output word: one 5-5-5-1 pixel plus the end-of-block flag.
    typedef struct packed {
        logic [4:0] red_out;
        logic [4:0] green_out;
        logic [4:0] blue_out;
        logic       alpha_bit;
        logic       block_end;
    } pixel_out_t;

    // Per-pixel control carried from the input stage to the reducer.
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic                      last;
    } pixel_ctrl_t;

endpackage

>>> rtl/ordered_dither_rgb32_to_rgb16_top.sv
// ----------------------------------------------------------------------------
// Ordered dither RGBA8888 to RGB5551 reducer, top level
// An accepted input word passes the input register, then the output register.
// Throughput: one word per cycle while out_stall is low; the two registers
// carry the pipeline, and the output register sets the stall point.
// Reset (rst_n, async low): pipeline empty, block position 0, dither off.
// ----------------------------------------------------------------------------
`include "ordered_dither_rgb32_to_rgb16_top_assert.svh"

module ordered_dither_rgb32_to_rgb16_top #(
    parameter int BLOCK_SIDE = odrgb_pkg::BLOCK_SIDE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  odrgb_pkg::pixel_in_t  in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output odrgb_pkg::pixel_out_t out_word
);

    localparam int RC_W = $clog2(BLOCK_SIDE);
    localparam logic [RC_W-1:0] RC_LAST = RC_W'(BLOCK_SIDE - 1);

    logic                   dither_en_reg;
    logic [RC_W-1:0]        row_reg;
    logic [RC_W-1:0]        row_next;
    logic [RC_W-1:0]        col_reg;
    logic [RC_W-1:0]        col_next;
    logic                   pos_last;
    logic                   in_accept;
    logic                   s1_advance;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    odrgb_pkg::pixel_in_t   s1_pixel_reg;
    odrgb_pkg::pixel_ctrl_t s1_ctrl_reg;
    odrgb_pkg::pixel_ctrl_t s1_ctrl_next;
    odrgb_pkg::pixel_out_t  reduced;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    odrgb_pkg::pixel_out_t  out_word_reg;

    // Dither enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            dither_en_reg <= cfg_wr_data;
        end
    end

    // Handshake: the input stage moves on when the output register is free.
    always_comb
    begin
        s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall   = s1_valid_reg && !s1_advance;
        in_accept  = in_valid && !in_stall;
    end

    // Row and column counters within the macroblock.
    always_comb
    begin
        pos_last = (row_reg == RC_LAST) && (col_reg == RC_LAST);
        row_next = row_reg;
        col_next = col_reg;
        if (in_accept)
        begin
            if (col_reg == RC_LAST)
            begin
                col_next = '0;
                row_next = (row_reg == RC_LAST) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Coefficient pick for the pixel being accepted.
    always_comb
    begin
        s1_ctrl_next.coeff = dither_en_reg
                           ? odrgb_pkg::DITHER_MATRIX[row_reg[1:0]][col_reg[1:0]]
                           : '0;
        s1_ctrl_next.last  = pos_last;
        s1_valid_next      = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= in_word;
            s1_ctrl_reg  <= s1_ctrl_next;
        end
    end

    // Channel reduction between the two registers.
    odrgb_reduce u_reduce (
        .pixel  (s1_pixel_reg),
        .ctrl   (s1_ctrl_reg),
        .result (reduced)
    );

    // Output register.
    always_comb
    begin
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_word_reg <= reduced;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The input side stalls only behind a full input register.
    `ODRGB_ASSERT_ALWAYS(a_stall_needs_s1, clk, in_stall |-> s1_valid_reg)
    // A word leaving the input register shows up at the output next cycle.
    `ODRGB_ASSERT(a_advance_to_out, clk, rst_n, s1_advance |=> out_valid)
    // Accepting the last pixel of a block wraps the position to the start.
    `ODRGB_ASSERT(a_block_wrap, clk, rst_n,
        (in_accept && pos_last) |=> (row_reg == '0 && col_reg == '0))
    // With dithering off, the captured coefficient is zero.
    `ODRGB_ASSERT(a_no_dither_coeff, clk, rst_n,
        (in_accept && !dither_en_reg) |=> (s1_ctrl_reg.coeff == '0))

endmodule

>>> rtl/odrgb_reduce.sv
// ----------------------------------------------------------------------------
// Ordered dither channel reducer
// Adds the dither coefficient to each color channel, clamps to 0..255 and
// keeps the top five bits; also forms the alpha bit and the end flag.
// ----------------------------------------------------------------------------
module odrgb_reduce (
    input  odrgb_pkg::pixel_in_t   pixel,
    input  odrgb_pkg::pixel_ctrl_t ctrl,
    output odrgb_pkg::pixel_out_t  result
);

    // Add, clamp and truncate one 8-bit channel.
    function automatic logic [4:0] reduce_channel(
        input logic [7:0]                            value,
        input logic signed [odrgb_pkg::COEFF_W-1:0] coeff
    );
        logic signed [9:0] sum;
        logic [4:0]        res;
        sum = $signed({2'b00, value})
            + $signed({{(10 - odrgb_pkg::COEFF_W){coeff[odrgb_pkg::COEFF_W-1]}}, coeff});
        if (sum[9])
        begin
            res = 5'd0;
        end
        else if (sum[8])
        begin
            res = 5'd31;
        end
        else
        begin
            res = sum[7:3];
        end
        return res;
    endfunction

    // Reduce the three color channels and pass the flags.
    always_comb
    begin
        result.red_out   = reduce_channel(pixel.red_in, ctrl.coeff);
        result.green_out = reduce_channel(pixel.green_in, ctrl.coeff);
        result.blue_out  = reduce_channel(pixel.blue_in, ctrl.coeff);
        result.alpha_bit = (pixel.alpha_in == odrgb_pkg::ALPHA_MATCH);
        result.block_end = ctrl.last;
    end

endmodule
